// ----- src/tlw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlw_pkg
// Shared types, constants and helpers of the text line wrapper.
// ----------------------------------------------------------------------------
package tlw_pkg;

  localparam int LINE_BUF    = 32;
  localparam int AW          = $clog2(LINE_BUF);
  localparam int FILL_W      = $clog2(LINE_BUF + 1);
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int COORD_W     = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 14;

  localparam logic [COORD_W-1:0] COORD_MAX = 14'h3FFF;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [6:0] CH_HYPHEN  = 7'h2D;
  localparam logic [6:0] GLYPH_SPACE = 7'h20;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_GAP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_WRAP    = 3'd7;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         glyph_code;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               segment_end;
    logic               run_last;
  } out_item_t;

  // Control from the layout sequencer to the output stage.
  typedef struct packed {
    logic push;  // one glyph offered
    logic fin;   // the current item has produced all its glyphs
  } ostg_ctl_t;

  function automatic logic [COORD_W-1:0] sat14(input logic [15:0] v);
    sat14 = (v > {2'b00, COORD_MAX}) ? COORD_MAX : v[COORD_W-1:0];
  endfunction

endpackage

// ----- src/text_line_wrapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_wrapper
// Lays out a byte stream into lines of a fixed-cell font and emits every
// placed glyph with its pixel position.
// ----------------------------------------------------------------------------
// Usage: text bytes enter on the in_ channel (valid/ready), one item per
// byte, with end_of_text on the last byte of a text. Each placed glyph leaves
// on the out_ channel as one item; run_last marks the final glyph caused by
// an input item, segment_end the final glyph of a flushed segment. The eight
// layout registers are written on the cfg_ port while the block is idle.
// A byte that is only stored passes accept, check, tail and finish before
// the next byte is taken. Flushing a segment reads each glyph from the line
// store and hands it off, waiting while the output stage is full. A break
// at the last space scans the store backwards, a read and a compare per
// cell, then moves the rest of the word to the front, a read and a write
// per cell. The line store serves one registered read and at most one
// write a cycle. One item is worked at a time.
// Reset: registers take their reset values, the pen returns to the origin,
// the store is empty and no clearing pass is needed.
// Stall: the output register and a one-glyph holdback stage absorb a stalled
// receiver; the sequencer then waits and no glyph is lost.
// ----------------------------------------------------------------------------
module text_line_wrapper (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tlw_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tlw_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [tlw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tlw_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_SCAN_RD   = 4'd2;
  localparam logic [3:0] S_SCAN_CMP  = 4'd3;
  localparam logic [3:0] S_EMIT_RD   = 4'd4;
  localparam logic [3:0] S_EMIT_PUSH = 4'd5;
  localparam logic [3:0] S_POST      = 4'd6;
  localparam logic [3:0] S_COPY_RD   = 4'd7;
  localparam logic [3:0] S_COPY_WR   = 4'd8;
  localparam logic [3:0] S_MOVE_RD   = 4'd9;
  localparam logic [3:0] S_MOVE_WR   = 4'd10;
  localparam logic [3:0] S_TAIL      = 4'd11;
  localparam logic [3:0] S_FIN       = 4'd12;

  // What follows a segment flush.
  localparam logic [2:0] P_BREAK   = 3'd0;  // plain break, retry the byte
  localparam logic [2:0] P_NL_TAIL = 3'd1;  // new line, byte consumed
  localparam logic [2:0] P_FULL    = 3'd2;  // full store, same line
  localparam logic [2:0] P_HYPHEN  = 3'd3;  // hyphen split
  localparam logic [2:0] P_SPLIT   = 3'd4;  // break at the last space
  localparam logic [2:0] P_TAIL    = 3'd5;  // end of text flush

  // Layout registers.
  logic [COORD_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt, wl_r, wl_nxt, hl_r, hl_nxt;
  logic [7:0]         gap_r, gap_nxt;
  logic [6:0]         cw_r, cw_nxt, ch_r, ch_nxt;
  logic               ww_r, ww_nxt;

  // Layout state.
  logic [3:0]         state_r, state_nxt;
  logic [2:0]         post_r, post_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [COORD_W-1:0] segx_r, segx_nxt, penx_r, penx_nxt, peny_r, peny_nxt;
  logic               halted_r, halted_nxt;
  logic [7:0]         chr_r, chr_nxt;
  logic               eot_r, eot_nxt;
  logic [FILL_W-1:0]  idx_r, idx_nxt, cnt_r, cnt_nxt, s_r, s_nxt;
  logic [FILL_W-1:0]  src_r, src_nxt, dst_r, dst_nxt;
  logic [COORD_W-1:0] x_r, x_nxt;
  logic               hyph_r, hyph_nxt;

  // Line store.
  logic [6:0]         mem [LINE_BUF];
  logic [6:0]         rd_data_r;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [6:0]         wr_data;
  logic               mem_we;

  // Arithmetic.
  logic signed [15:0] rel_y, rel_x;
  logic               over_h, over_w;
  logic [FILL_W-1:0]  mul_a, s_m1, fill_m1;
  logic [FILL_W+6:0]  prod;
  logic [COORD_W-1:0] nl_y, full_x, rest_x, hyph_x, pen_inc, x_inc;
  logic               last_glyph;

  ostg_ctl_t          ctl;
  out_item_t          glyph;
  logic               take;

  assign in_ready = (state_r == S_IDLE);

  assign rel_y  = $signed({2'b00, peny_r}) - $signed({2'b00, oy_r});
  assign rel_x  = $signed({2'b00, penx_r}) - $signed({2'b00, ox_r})
                + $signed({9'd0, cw_r});
  assign over_h = (hl_r != '0) && (rel_y > $signed({2'b00, hl_r}));
  assign over_w = (wl_r != '0) && (rel_x > $signed({2'b00, wl_r}));

  // One shared multiplier: full-store advance or length of the moved word.
  assign mul_a   = (state_r == S_MOVE_RD) ? dst_r : fill_r;
  assign prod    = mul_a * cw_r;
  assign s_m1    = s_r - FILL_W'(1);
  assign fill_m1 = fill_r - FILL_W'(1);

  assign nl_y    = sat14({2'b00, peny_r} + {9'd0, ch_r} + {8'd0, gap_r});
  assign full_x  = sat14({2'b00, penx_r} + 16'(prod));
  assign rest_x  = sat14({2'b00, ox_r} + 16'(prod));
  assign hyph_x  = sat14({2'b00, ox_r} + {9'd0, cw_r});
  assign pen_inc = sat14({2'b00, penx_r} + {9'd0, cw_r});
  assign x_inc   = sat14({2'b00, x_r} + {9'd0, cw_r});

  assign last_glyph = (idx_r + FILL_W'(1)) == cnt_r;

  always_comb begin
    glyph.glyph_code  = (hyph_r && last_glyph) ? CH_HYPHEN : rd_data_r;
    glyph.pixel_x     = x_r;
    glyph.pixel_y     = peny_r;
    glyph.segment_end = last_glyph;
    glyph.run_last    = 1'b0;
  end

  // Read address follows the sequencer state.
  always_comb begin
    case (state_r)
      S_SCAN_RD: rd_addr = s_m1[AW-1:0];
      S_COPY_RD: rd_addr = fill_m1[AW-1:0];
      S_MOVE_RD: rd_addr = src_r[AW-1:0];
      default:   rd_addr = idx_r[AW-1:0];
    endcase
  end

  always_comb begin
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    wl_nxt     = wl_r;
    hl_nxt     = hl_r;
    gap_nxt    = gap_r;
    cw_nxt     = cw_r;
    ch_nxt     = ch_r;
    ww_nxt     = ww_r;
    state_nxt  = state_r;
    post_nxt   = post_r;
    fill_nxt   = fill_r;
    segx_nxt   = segx_r;
    penx_nxt   = penx_r;
    peny_nxt   = peny_r;
    halted_nxt = halted_r;
    chr_nxt    = chr_r;
    eot_nxt    = eot_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    s_nxt      = s_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    x_nxt      = x_r;
    hyph_nxt   = hyph_r;
    mem_we     = 1'b0;
    wr_addr    = fill_r[AW-1:0];
    wr_data    = chr_r[6:0];
    ctl.push   = 1'b0;
    ctl.fin    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          chr_nxt   = in_data.char_code;
          eot_nxt   = in_data.end_of_text;
          state_nxt = halted_r ? S_FIN : S_CHECK;
        end
      end

      S_CHECK: begin
        // Flush setup shared by every branch that empties the store.
        idx_nxt  = '0;
        x_nxt    = segx_r;
        hyph_nxt = 1'b0;
        cnt_nxt  = fill_r;
        if (over_h) begin
          halted_nxt = 1'b1;
          state_nxt  = S_TAIL;
        end else if (over_w) begin
          if (fill_r == '0) begin
            halted_nxt = 1'b1;
            state_nxt  = S_TAIL;
          end else if (!ww_r) begin
            post_nxt  = P_BREAK;
            state_nxt = S_EMIT_RD;
          end else if (chr_r == CH_SPACE) begin
            post_nxt  = P_NL_TAIL;
            state_nxt = S_EMIT_RD;
          end else begin
            s_nxt     = fill_r;
            state_nxt = S_SCAN_RD;
          end
        end else if (fill_r >= FILL_W'(LINE_BUF)) begin
          post_nxt  = P_FULL;
          state_nxt = S_EMIT_RD;
        end else if (chr_r == CH_NEWLINE) begin
          post_nxt  = P_NL_TAIL;
          state_nxt = (fill_r == '0) ? S_POST : S_EMIT_RD;
        end else if (chr_r inside {[CH_SPACE:CH_TILDE]}) begin
          mem_we    = 1'b1;
          fill_nxt  = fill_r + FILL_W'(1);
          penx_nxt  = pen_inc;
          state_nxt = S_TAIL;
        end else begin
          state_nxt = S_TAIL;
        end
      end

      S_SCAN_RD: begin
        if (s_r == '0) begin
          // No space in the word: split it with a hyphen, unless one cell
          // is all the line could ever hold.
          if (fill_r == FILL_W'(1)) begin
            halted_nxt = 1'b1;
            state_nxt  = S_TAIL;
          end else begin
            idx_nxt   = '0;
            cnt_nxt   = fill_r;
            x_nxt     = segx_r;
            hyph_nxt  = 1'b1;
            post_nxt  = P_HYPHEN;
            state_nxt = S_EMIT_RD;
          end
        end else begin
          s_nxt     = s_m1;
          state_nxt = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (rd_data_r == GLYPH_SPACE) begin
          idx_nxt   = '0;
          cnt_nxt   = s_r;
          x_nxt     = segx_r;
          hyph_nxt  = 1'b0;
          post_nxt  = P_SPLIT;
          state_nxt = (s_r == '0) ? S_POST : S_EMIT_RD;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end

      S_EMIT_RD: begin
        state_nxt = S_EMIT_PUSH;
      end

      S_EMIT_PUSH: begin
        ctl.push = 1'b1;
        if (take) begin
          idx_nxt   = idx_r + FILL_W'(1);
          x_nxt     = x_inc;
          state_nxt = last_glyph ? S_POST : S_EMIT_RD;
        end
      end

      S_POST: begin
        case (post_r)
          P_BREAK: begin
            peny_nxt  = nl_y;
            segx_nxt  = ox_r;
            penx_nxt  = ox_r;
            fill_nxt  = '0;
            state_nxt = S_CHECK;
          end
          P_NL_TAIL: begin
            peny_nxt  = nl_y;
            segx_nxt  = ox_r;
            penx_nxt  = ox_r;
            fill_nxt  = '0;
            state_nxt = S_TAIL;
          end
          P_FULL: begin
            penx_nxt  = full_x;
            segx_nxt  = full_x;
            fill_nxt  = '0;
            state_nxt = S_CHECK;
          end
          P_HYPHEN: begin
            state_nxt = S_COPY_RD;
          end
          P_SPLIT: begin
            src_nxt   = s_r + FILL_W'(1);
            dst_nxt   = '0;
            state_nxt = S_MOVE_RD;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_COPY_RD: begin
        state_nxt = S_COPY_WR;
      end

      S_COPY_WR: begin
        // The glyph that gave way to the hyphen starts the new line.
        mem_we    = 1'b1;
        wr_addr   = '0;
        wr_data   = rd_data_r;
        peny_nxt  = nl_y;
        segx_nxt  = ox_r;
        penx_nxt  = hyph_x;
        fill_nxt  = FILL_W'(1);
        state_nxt = S_CHECK;
      end

      S_MOVE_RD: begin
        if (src_r == fill_r) begin
          peny_nxt  = nl_y;
          segx_nxt  = ox_r;
          penx_nxt  = rest_x;
          fill_nxt  = dst_r;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_MOVE_WR;
        end
      end

      S_MOVE_WR: begin
        mem_we    = 1'b1;
        wr_addr   = dst_r[AW-1:0];
        wr_data   = rd_data_r;
        src_nxt   = src_r + FILL_W'(1);
        dst_nxt   = dst_r + FILL_W'(1);
        state_nxt = S_MOVE_RD;
      end

      S_TAIL: begin
        if (eot_r && !halted_r && (fill_r != '0)) begin
          idx_nxt   = '0;
          cnt_nxt   = fill_r;
          x_nxt     = segx_r;
          hyph_nxt  = 1'b0;
          post_nxt  = P_TAIL;
          state_nxt = S_EMIT_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        ctl.fin = 1'b1;
        if (take) begin
          if (eot_r) begin
            fill_nxt   = '0;
            halted_nxt = 1'b0;
            segx_nxt   = ox_r;
            penx_nxt   = ox_r;
            peny_nxt   = oy_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The user, not the block, limits configuration writes to sequencer idle.
    if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: begin
          ox_nxt   = cfg_data;
          penx_nxt = cfg_data;
          segx_nxt = cfg_data;
        end
        REG_ORIGIN_Y: begin
          oy_nxt   = cfg_data;
          peny_nxt = cfg_data;
        end
        REG_WIDTH_LIMIT:  wl_nxt  = cfg_data;
        REG_HEIGHT_LIMIT: hl_nxt  = cfg_data;
        REG_LINE_GAP:     gap_nxt = cfg_data[7:0];
        REG_CELL_WIDTH:   cw_nxt  = cfg_data[6:0];
        REG_CELL_HEIGHT:  ch_nxt  = cfg_data[6:0];
        REG_WORD_WRAP:    ww_nxt  = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r     <= '0;
      oy_r     <= '0;
      wl_r     <= '0;
      hl_r     <= '0;
      gap_r    <= '0;
      cw_r     <= 7'd6;
      ch_r     <= 7'd12;
      ww_r     <= 1'b1;
      state_r  <= S_IDLE;
      post_r   <= P_TAIL;
      fill_r   <= '0;
      segx_r   <= '0;
      penx_r   <= '0;
      peny_r   <= '0;
      halted_r <= 1'b0;
    end else begin
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      wl_r     <= wl_nxt;
      hl_r     <= hl_nxt;
      gap_r    <= gap_nxt;
      cw_r     <= cw_nxt;
      ch_r     <= ch_nxt;
      ww_r     <= ww_nxt;
      state_r  <= state_nxt;
      post_r   <= post_nxt;
      fill_r   <= fill_nxt;
      segx_r   <= segx_nxt;
      penx_r   <= penx_nxt;
      peny_r   <= peny_nxt;
      halted_r <= halted_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    chr_r  <= chr_nxt;
    eot_r  <= eot_nxt;
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    s_r    <= s_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    x_r    <= x_nxt;
    hyph_r <= hyph_nxt;
  end

  // Line store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  tlw_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .glyph     (glyph),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The store never holds more glyphs than it has cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(LINE_BUF))
    else $error("line store fill count beyond its depth");

  // A halted block stores nothing.
  a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !halted_r)
    else $error("line store written while halted");

  // Finishing a text returns the layout to its start.
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && take && eot_r) |=> (fill_r == '0 && !halted_r))
    else $error("end of text did not clear the layout state");

  // A glyph is only offered with a nonempty segment in flight.
  a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> (idx_r < cnt_r))
    else $error("glyph offered outside its segment");

endmodule

// ----- src/tlw_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlw_out_stage
// Holds back one glyph so the last glyph of an item can carry run_last,
// caps the glyphs of one item and drives the registered result channel.
// ----------------------------------------------------------------------------
module tlw_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlw_pkg::ostg_ctl_t   ctl,
  input  tlw_pkg::out_item_t   glyph,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlw_pkg::out_item_t   out_data
);
  import tlw_pkg::*;

  out_item_t        pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_v_r, out_v_nxt;
  logic [RES_W-1:0] cnt_r, cnt_nxt;
  logic             slot_free;

  assign slot_free = !out_v_r || out_ready;
  assign take      = !pend_v_r || slot_free;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_ready;
    cnt_nxt    = cnt_r;
    if (ctl.push && take && (cnt_r < RES_W'(MAX_RESULTS))) begin
      if (pend_v_r) begin
        out_nxt   = pend_r;
        out_v_nxt = 1'b1;
      end
      pend_nxt          = glyph;
      pend_nxt.run_last = 1'b0;
      pend_v_nxt        = 1'b1;
      cnt_nxt           = cnt_r + RES_W'(1);
    end else if (ctl.fin && take) begin
      if (pend_v_r) begin
        out_nxt          = pend_r;
        out_nxt.run_last = 1'b1;
        out_v_nxt        = 1'b1;
      end
      pend_v_nxt = 1'b0;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ----- dv/tb_text_line_wrapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_line_wrapper
// Self-checking bench for the text line wrapper.
// ----------------------------------------------------------------------------
// A directed table covers the extremes first: dropped control bytes, the
// newline, space breaks, hyphen splits, plain breaks, three kinds of halt and
// coordinate saturation. Random phases follow, each under a fresh register
// setting. Every glyph that leaves the block is compared, field by field,
// with the oldest glyph that the bench's own layout predictor expects.
// ----------------------------------------------------------------------------
module tb_text_line_wrapper;
  import tlw_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  text_line_wrapper u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Layout registers as the predictor sees them.
  int org_x, org_y, wlim, hlim, gap, cw, ch;
  bit wrap;
  // Layout state: the glyphs waiting in the line, pen and halt flag.
  logic [6:0] line_glyphs[LINE_BUF];
  int fill, seg_x, pen_x, pen_y;
  bit halt;

  out_item_t step_glyphs[$];     // glyphs caused by the item being predicted
  out_item_t pending_glyphs[$];  // glyphs expected and not yet seen

  int errors;
  int items_sent;
  int glyphs_seen;
  int settings_used;
  int cycles;
  bit quiet;      // no idling on either side while set
  int word_left;  // letters left in the current random word

  function automatic logic [COORD_W-1:0] clip(input int v);
    return (v > 16383) ? COORD_MAX : v[COORD_W-1:0];
  endfunction

  task automatic emit_line(input int count);
    out_item_t g;
    for (int i = 0; i < count && i < LINE_BUF; i++) begin
      if (step_glyphs.size() < MAX_RESULTS) begin
        g.glyph_code  = line_glyphs[i];
        g.pixel_x     = clip(seg_x + i * cw);
        g.pixel_y     = pen_y[COORD_W-1:0];
        g.segment_end = (i + 1 == count);
        g.run_last    = 1'b0;
        step_glyphs.push_back(g);
      end
    end
  endtask

  task automatic next_line();
    pen_y = clip(pen_y + ch + gap);
    seg_x = org_x;
    pen_x = org_x;
  endtask

  // Works out every glyph that one text byte causes and queues them.
  task automatic predict_layout(input in_item_t it);
    logic [7:0] c;
    logic [6:0] moved;
    bit consumed;
    bit found;
    int rel_x, rel_y, s, rest;
    c = it.char_code;
    step_glyphs.delete();
    if (!halt) begin
      consumed = 1'b0;
      while (!consumed && !halt) begin
        rel_y = pen_y - org_y;
        rel_x = pen_x - org_x + cw;
        if (hlim != 0 && rel_y > hlim) begin
          halt = 1'b1;
          break;
        end
        if (wlim != 0 && rel_x > wlim) begin
          if (fill == 0) begin
            halt = 1'b1;
            break;
          end
          if (!wrap) begin
            emit_line(fill);
            next_line();
            fill = 0;
          end else if (c == CH_SPACE) begin
            // A space at the limit just ends the line and is dropped.
            emit_line(fill);
            next_line();
            fill = 0;
            consumed = 1'b1;
          end else begin
            s = fill;
            found = 1'b0;
            while (s > 0) begin
              s--;
              if (line_glyphs[s] == GLYPH_SPACE) begin
                found = 1'b1;
                break;
              end
            end
            if (!found) begin
              // A word of one glyph cannot be split any further.
              if (fill == 1) begin
                halt = 1'b1;
                break;
              end
              moved = line_glyphs[fill-1];
              line_glyphs[fill-1] = CH_HYPHEN;
              emit_line(fill);
              next_line();
              pen_x = clip(org_x + cw);
              fill = 1;
              line_glyphs[0] = moved;
            end else begin
              rest = fill - s - 1;
              emit_line(s);
              for (int k = 0; k < rest; k++) line_glyphs[k] = line_glyphs[s+1+k];
              next_line();
              fill = rest;
              pen_x = clip(org_x + rest * cw);
            end
          end
          continue;
        end
        if (fill >= LINE_BUF) begin
          // A full line store flushes and carries on along the same line.
          emit_line(fill);
          pen_x = clip(pen_x + fill * cw);
          seg_x = pen_x;
          fill = 0;
          continue;
        end
        if (c == CH_NEWLINE) begin
          emit_line(fill);
          next_line();
          fill = 0;
        end else if (c >= CH_SPACE && c <= CH_TILDE) begin
          line_glyphs[fill] = c[6:0];
          fill++;
          pen_x = clip(pen_x + cw);
        end
        consumed = 1'b1;
      end
      if (it.end_of_text && !halt && fill > 0) emit_line(fill);
    end
    if (it.end_of_text) begin
      fill = 0;
      halt = 1'b0;
      seg_x = org_x;
      pen_x = org_x;
      pen_y = org_y;
    end
    if (step_glyphs.size() > 0) step_glyphs[step_glyphs.size()-1].run_last = 1'b1;
    foreach (step_glyphs[i]) pending_glyphs.push_back(step_glyphs[i]);
  endtask

  // Writes one layout register and mirrors it in the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ORIGIN_X: begin
        org_x = val & 16383;
        pen_x = org_x;
        seg_x = org_x;
      end
      REG_ORIGIN_Y: begin
        org_y = val & 16383;
        pen_y = org_y;
      end
      REG_WIDTH_LIMIT:  wlim = val & 16383;
      REG_HEIGHT_LIMIT: hlim = val & 16383;
      REG_LINE_GAP:     gap = val & 255;
      REG_CELL_WIDTH:   cw = val & 127;
      REG_CELL_HEIGHT:  ch = val & 127;
      REG_WORD_WRAP:    wrap = val[0];
      default: ;
    endcase
  endtask

  // Stops sending and lets the block drain completely. Bytes that cause no
  // glyph may still be in work when the queue empties, hence the extra wait.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one byte, holds it until it is taken, then predicts its glyphs.
  task automatic send_char(input logic [7:0] c, input bit eot);
    if (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.char_code   <= c;
    in_data.end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_layout('{char_code: c, end_of_text: eot});
  endtask

  // Random text: mostly words of printable bytes between spaces, some
  // newlines and now and then an arbitrary byte.
  function automatic logic [7:0] random_char();
    int r;
    if (word_left > 0) begin
      word_left--;
      return 8'($urandom_range(33, 126));
    end
    r = $urandom_range(99);
    if (r < 8) return CH_NEWLINE;
    if (r < 16) return 8'($urandom_range(0, 255));
    word_left = $urandom_range(1, 12);
    return CH_SPACE;
  endfunction

  // Directed table. A row either writes a register (after the block is
  // drained) or sends one byte; a few rows carry the first glyph by hand.
  typedef enum logic { ROW_CHAR, ROW_REG } row_kind_e;
  typedef struct {
    row_kind_e kind;
    logic [CFG_IDX_W-1:0] idx;
    int val;
    logic [7:0] c;
    bit eot;
    bit typed;
    out_item_t want;
  } row_t;

  function automatic row_t chr(input logic [7:0] c, input bit eot);
    row_t r;
    r = '{kind: ROW_CHAR, idx: '0, val: 0, c: c, eot: eot, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    row_t r;
    r = '{kind: ROW_REG, idx: idx, val: val, c: '0, eot: 1'b0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t typed_chr(input logic [7:0] c, input bit eot, input out_item_t w);
    row_t r;
    r = chr(c, eot);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  row_t plan[$];

  task automatic build_plan();
    string words;
    // Reset values: one glyph at the origin, ending its line and its item.
    plan.push_back(typed_chr("A", 1'b1, '{7'h41, 14'd0, 14'd0, 1'b1, 1'b1}));
    // Control bytes are dropped; newline flushes "~ " at the top row.
    plan.push_back(chr(8'h00, 1'b0));
    plan.push_back(chr(8'hFF, 1'b0));
    plan.push_back(chr("~", 1'b0));
    plan.push_back(chr(" ", 1'b0));
    plan.push_back(chr(CH_NEWLINE, 1'b0));
    plan.push_back(chr("!", 1'b1));
    // Five cells per line: a break at the last space, then a hyphen split,
    // then a space that lands on the limit.
    plan.push_back(reg_row(REG_WIDTH_LIMIT, 30));
    words = "ab cdefghijk";
    foreach (words[i]) plan.push_back(chr(words[i], 1'b0));
    plan.push_back(chr(" ", 1'b0));
    plan.push_back(chr("z", 1'b1));
    // Plain breaks, two cells per line.
    plan.push_back(reg_row(REG_WORD_WRAP, 0));
    plan.push_back(reg_row(REG_WIDTH_LIMIT, 12));
    plan.push_back(chr("p", 1'b0));
    plan.push_back(chr("q", 1'b0));
    plan.push_back(chr("r", 1'b1));
    // One cell per line: a one-glyph word cannot split, the block halts.
    plan.push_back(reg_row(REG_WORD_WRAP, 1));
    plan.push_back(reg_row(REG_WIDTH_LIMIT, 6));
    plan.push_back(chr("x", 1'b0));
    plan.push_back(typed_chr("y", 1'b1, '0));
    // Narrower than a cell: halts with an empty line.
    plan.push_back(reg_row(REG_WIDTH_LIMIT, 3));
    plan.push_back(chr("q", 1'b1));
    // Height limit of one row: the second line halts.
    plan.push_back(reg_row(REG_WIDTH_LIMIT, 0));
    plan.push_back(reg_row(REG_HEIGHT_LIMIT, 1));
    plan.push_back(chr(CH_NEWLINE, 1'b0));
    plan.push_back(chr("m", 1'b1));
    // Largest origin and gap, 64-pixel cells: every coordinate saturates.
    plan.push_back(reg_row(REG_HEIGHT_LIMIT, 0));
    plan.push_back(reg_row(REG_ORIGIN_X, 16383));
    plan.push_back(reg_row(REG_ORIGIN_Y, 16383));
    plan.push_back(reg_row(REG_CELL_WIDTH, 64));
    plan.push_back(reg_row(REG_CELL_HEIGHT, 64));
    plan.push_back(reg_row(REG_LINE_GAP, 255));
    plan.push_back(chr("E", 1'b0));
    plan.push_back(chr("e", 1'b0));
    plan.push_back(chr(CH_NEWLINE, 1'b0));
    plan.push_back(typed_chr("F", 1'b1, '{7'h46, 14'h3FFF, 14'h3FFF, 1'b1, 1'b1}));
  endtask

  task automatic random_setting(input int phase);
    int w;
    settle();
    settings_used++;
    write_reg(REG_ORIGIN_X, $urandom_range(0, 16383) >> $urandom_range(0, 13));
    write_reg(REG_ORIGIN_Y, $urandom_range(0, 16383) >> $urandom_range(0, 13));
    write_reg(REG_CELL_WIDTH, ($urandom_range(99) < 80) ? $urandom_range(1, 10)
                                                       : $urandom_range(1, 64));
    write_reg(REG_CELL_HEIGHT, $urandom_range(1, 64));
    write_reg(REG_LINE_GAP, $urandom_range(0, 255));
    write_reg(REG_WORD_WRAP, $urandom_range(0, 1));
    // Phase 0 runs unlimited, so long lines fill the whole store.
    w = (phase == 0) ? 0 : cw * $urandom_range(2, 40);
    if (phase == 3) w = $urandom_range(0, 16383);
    write_reg(REG_WIDTH_LIMIT, w);
    write_reg(REG_HEIGHT_LIMIT, (phase == 2) ? $urandom_range(1, 200)
                                             : ((phase == 3) ? 16383 : 0));
  endtask

  // Receiver: random stalls, and a check of every glyph taken.
  always @(posedge clk) begin
    out_item_t exp_g;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 19);
      if (out_valid && out_ready) begin
        glyphs_seen++;
        if (pending_glyphs.size() == 0) begin
          errors++;
          $display("%0t: unexpected glyph, expected none, actual %p", $time, out_data);
        end else begin
          exp_g = pending_glyphs.pop_front();
          if (out_data.glyph_code !== exp_g.glyph_code) begin
            errors++;
            $display("%0t: glyph_code expected %h actual %h",
                     $time, exp_g.glyph_code, out_data.glyph_code);
          end
          if (out_data.pixel_x !== exp_g.pixel_x) begin
            errors++;
            $display("%0t: pixel_x expected %0d actual %0d",
                     $time, exp_g.pixel_x, out_data.pixel_x);
          end
          if (out_data.pixel_y !== exp_g.pixel_y) begin
            errors++;
            $display("%0t: pixel_y expected %0d actual %0d",
                     $time, exp_g.pixel_y, out_data.pixel_y);
          end
          if (out_data.segment_end !== exp_g.segment_end) begin
            errors++;
            $display("%0t: segment_end expected %b actual %b",
                     $time, exp_g.segment_end, out_data.segment_end);
          end
          if (out_data.run_last !== exp_g.run_last) begin
            errors++;
            $display("%0t: run_last expected %b actual %b",
                     $time, exp_g.run_last, out_data.run_last);
          end
        end
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d glyphs outstanding", $time, pending_glyphs.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    glyphs_seen = 0;
    settings_used = 1;
    cycles = 0;
    quiet = 1'b0;
    word_left = 0;
    // Predictor starts from the reset values of the block.
    org_x = 0; org_y = 0; wlim = 0; hlim = 0; gap = 0; cw = 6; ch = 12; wrap = 1'b1;
    fill = 0; seg_x = 0; pen_x = 0; pen_y = 0; halt = 1'b0;
    foreach (line_glyphs[i]) line_glyphs[i] = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Hand-typed glyphs cross-check the predictor itself.
    build_plan();
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        settle();
        settings_used++;
        write_reg(plan[r].idx, plan[r].val);
      end else begin
        send_char(plan[r].c, plan[r].eot);
        if (plan[r].typed && (step_glyphs.size() == 0 ? (plan[r].want !== '0)
                                                       : (step_glyphs[0] !== plan[r].want))) begin
          errors++;
          $display("%0t: row %0d expected %p actual prediction %p", $time, r,
                   plan[r].want, step_glyphs.size() ? step_glyphs[0] : '0);
        end
      end
    end

    // Random part: four settings, 36 bytes each. The second phase
    // runs with neither side idling.
    for (int phase = 0; phase < 4; phase++) begin
      random_setting(phase);
      quiet = (phase == 1);
      for (int k = 0; k < 35; k++) send_char(random_char(), $urandom_range(99) < 4);
      send_char(random_char(), 1'b1);
      quiet = 1'b0;
    end

    settle();
    $display("Sent %0d text bytes under %0d register settings; %0d glyphs checked.",
             items_sent, settings_used, glyphs_seen);
    $display("Covered wraps, hyphen splits, plain breaks, halts, full lines and saturation.");
    if (errors == 0 && pending_glyphs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tlw_pkg.sv
src/tlw_out_stage.sv
src/text_line_wrapper.sv
dv/tb_text_line_wrapper.sv
